// File: rtl/pss_pkg.sv
// ----------------------------------------------------------------------------
// pss_pkg
// Types and constants shared by the swap sequence block, its channel
// interfaces and its checker.
// ----------------------------------------------------------------------------
package pss_pkg;

    // Width of a node id and of a position in a result item
    localparam int NODE_W      = 6;
    // Number of distinct node ids (depth of the position table)
    localparam int NODE_CNT    = 64;
    // Results per run are capped; the last one is flagged
    localparam int MAX_RESULTS = 63;
    localparam int RES_CNT_W   = 6;

    // Sequencer states
    typedef enum logic [2:0] {
        S_LOAD,   // take tour elements
        S_POS,    // read target and working entry at position i
        S_CMP,    // compare the two entries, skip matching positions
        S_LOOK,   // position table answers, read working entry at k
        S_SWAP,   // emit swap, exchange entries
        S_FIX0,   // position 0 swapped: copy entry 0 to the closing slot
        S_TEST,   // re-check position i after a swap
        S_FLUSH   // hand out the held result flagged as last
    } t_state;

endpackage

// File: rtl/pss_if.sv
// ----------------------------------------------------------------------------
// pss_in_if / pss_out_if
// Valid/ready channels of the swap sequence block: tour elements in,
// swap results out.
// ----------------------------------------------------------------------------

// Input channel: one tour element per item
interface pss_in_if import pss_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [NODE_W-1:0] target_node;
    logic [NODE_W-1:0] current_node;
    logic              last_element;

    modport source (output valid, target_node, current_node, last_element,
                    input ready);
    modport sink   (input valid, target_node, current_node, last_element,
                    output ready);
endinterface

// Output channel: one swap result per item
interface pss_out_if import pss_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [NODE_W-1:0] swap_first;
    logic [NODE_W-1:0] swap_second;
    logic              is_swap;
    logic              last_swap;

    modport source (output valid, swap_first, swap_second, is_swap, last_swap,
                    input ready);
    modport sink   (input valid, swap_first, swap_second, is_swap, last_swap,
                    output ready);
endinterface

// File: rtl/permutation_swap_sequence.sv
// Operation: loading stores each element as it arrives. After the last element the
//   run opens, compares each position, makes each swap through the lookup, swap and
//   re-check steps (plus a fix step at position 0), reopens after a swapped position, closes.
// Throughput: one element per cycle while loading; a run does at most one read
//   and one write of the working tour memory per cycle; output stalls hold a run.
// Reset: synchronous, active low; clears sequencer, counts, node mask, out valid.
// ----------------------------------------------------------------------------
// permutation_swap_sequence
// Loads a target tour and a current tour, then emits the swap sequence that
// turns the current tour into the target, one swap per item (empty marker if equal).
// ----------------------------------------------------------------------------
module permutation_swap_sequence import pss_pkg::*; #(
    parameter int TOUR_LEN = 64
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    pss_in_if.sink    i_in,
    pss_out_if.source o_out
);

    localparam int IDX_W = $clog2(TOUR_LEN);
    localparam int CNT_W = $clog2(TOUR_LEN + 1);

    // Memories and their registered read data
    logic [NODE_W-1:0] r_tgt_mem  [TOUR_LEN];
    logic [NODE_W-1:0] r_work_mem [TOUR_LEN];
    logic [IDX_W-1:0]  r_pos_mem  [NODE_CNT];
    logic [NODE_W-1:0] r_tgt_q;
    logic [NODE_W-1:0] r_work_q;
    logic [IDX_W-1:0]  r_pos_q;

    // Memory controls
    logic              tgt_we;
    logic [IDX_W-1:0]  tgt_ra;
    logic              work_we;
    logic [IDX_W-1:0]  work_wa;
    logic [NODE_W-1:0] work_wd;
    logic [IDX_W-1:0]  work_ra;
    logic              pos_we;
    logic [NODE_W-1:0] pos_ra;

    // Sequencer state
    t_state               r_state, n_state;
    logic [CNT_W-1:0]     r_lc, n_lc;
    logic [NODE_CNT-1:0]  r_mask, n_mask;
    logic [IDX_W-1:0]     r_i, n_i;
    logic [IDX_W-1:0]     r_k, n_k;
    logic [IDX_W-1:0]     r_lastpos, n_lastpos;
    logic [NODE_W-1:0]    r_cur, n_cur;
    logic [NODE_W-1:0]    r_tgt, n_tgt;
    logic [RES_CNT_W-1:0] r_cnt, n_cnt;
    logic                 r_pend_v, n_pend_v;
    logic [IDX_W-1:0]     r_pend_i, n_pend_i;
    logic [IDX_W-1:0]     r_pend_k, n_pend_k;

    // Output register
    logic              r_ovalid;
    logic [NODE_W-1:0] r_ofirst;
    logic [NODE_W-1:0] r_osecond;
    logic              r_ois;
    logic              r_olast;

    logic              in_ready;
    logic              out_free;
    logic              push;
    logic [NODE_W-1:0] push_first;
    logic [NODE_W-1:0] push_second;
    logic              push_is;
    logic              push_last;
    logic [IDX_W-1:0]  look_k;
    logic [NODE_W-1:0] work_k;

    assign out_free = !r_ovalid || o_out.ready;

    // Target position lookup: unknown node or out-of-range entry gives 0
    assign look_k = (r_mask[r_cur] && (r_pos_q <= r_lastpos)) ? r_pos_q : '0;

    // Entry at k; position i lives in r_cur until it is written back
    assign work_k = (r_k == r_i) ? r_cur : r_work_q;

    // Target tour memory
    always_ff @(posedge i_clk) begin
        if (tgt_we) begin
            r_tgt_mem[r_lc[IDX_W-1:0]] <= i_in.target_node;
        end
        r_tgt_q <= r_tgt_mem[tgt_ra];
    end

    // Working tour memory
    always_ff @(posedge i_clk) begin
        if (work_we) begin
            r_work_mem[work_wa] <= work_wd;
        end
        r_work_q <= r_work_mem[work_ra];
    end

    // Node -> target position table
    always_ff @(posedge i_clk) begin
        if (pos_we) begin
            r_pos_mem[i_in.target_node] <= r_lc[IDX_W-1:0];
        end
        r_pos_q <= r_pos_mem[pos_ra];
    end

    // Sequencer: next state, memory controls, result push
    always_comb begin
        n_state     = r_state;
        n_lc        = r_lc;
        n_mask      = r_mask;
        n_i         = r_i;
        n_k         = r_k;
        n_lastpos   = r_lastpos;
        n_cur       = r_cur;
        n_tgt       = r_tgt;
        n_cnt       = r_cnt;
        n_pend_v    = r_pend_v;
        n_pend_i    = r_pend_i;
        n_pend_k    = r_pend_k;
        in_ready    = 1'b0;
        tgt_we      = 1'b0;
        tgt_ra      = r_i;
        work_we     = 1'b0;
        work_wa     = r_i;
        work_wd     = r_cur;
        work_ra     = r_i;
        pos_we      = 1'b0;
        pos_ra      = r_cur;
        push        = 1'b0;
        push_first  = NODE_W'(r_pend_i);
        push_second = NODE_W'(r_pend_k);
        push_is     = 1'b1;
        push_last   = 1'b0;

        case (r_state)
            S_LOAD: begin
                in_ready = 1'b1;
                if (i_in.valid) begin
                    // store both nodes while there is room
                    if (r_lc < CNT_W'(TOUR_LEN)) begin
                        tgt_we  = 1'b1;
                        work_we = 1'b1;
                        work_wa = r_lc[IDX_W-1:0];
                        work_wd = i_in.current_node;
                        n_lc    = r_lc + 1'b1;
                    end
                    // record target position, never for the closing slot
                    if (!i_in.last_element && (r_lc < CNT_W'(TOUR_LEN - 1))) begin
                        pos_we                      = 1'b1;
                        n_mask[i_in.target_node] = 1'b1;
                    end
                    if (i_in.last_element) begin
                        n_state  = S_POS;
                        n_i      = '0;
                        n_cnt    = '0;
                        n_pend_v = 1'b0;
                        if (r_lc < CNT_W'(TOUR_LEN)) begin
                            n_lastpos = r_lc[IDX_W-1:0];
                        end else begin
                            n_lastpos = IDX_W'(TOUR_LEN - 1);
                        end
                    end
                end
            end

            S_POS: begin
                tgt_ra  = r_i;
                work_ra = r_i;
                n_state = S_CMP;
            end

            S_CMP: begin
                n_tgt = r_tgt_q;
                n_cur = r_work_q;
                if (r_tgt_q == r_work_q) begin
                    if (r_i == r_lastpos) begin
                        n_state = S_FLUSH;
                    end else begin
                        // next position read issued right away
                        n_i     = r_i + 1'b1;
                        tgt_ra  = r_i + 1'b1;
                        work_ra = r_i + 1'b1;
                    end
                end else begin
                    pos_ra  = r_work_q;
                    n_state = S_LOOK;
                end
            end

            S_LOOK: begin
                n_k     = look_k;
                work_ra = look_k;
                n_state = S_SWAP;
            end

            S_SWAP: begin
                work_ra = r_k;
                if (!r_pend_v || out_free) begin
                    // previous swap is known not to be the last one
                    push     = r_pend_v;
                    n_pend_v = 1'b1;
                    n_pend_i = r_i;
                    n_pend_k = r_k;
                    work_we  = 1'b1;
                    work_wa  = r_k;
                    work_wd  = r_cur;
                    n_cur    = work_k;
                    n_cnt    = r_cnt + 1'b1;
                    if (r_cnt == RES_CNT_W'(MAX_RESULTS - 1)) begin
                        n_state = S_FLUSH;
                    end else if (r_i == '0) begin
                        n_state = S_FIX0;
                    end else begin
                        n_state = S_TEST;
                    end
                end
            end

            S_FIX0: begin
                work_we = 1'b1;
                work_wa = r_lastpos;
                work_wd = r_cur;
                n_state = S_TEST;
            end

            S_TEST: begin
                if (r_cur != r_tgt) begin
                    pos_ra  = r_cur;
                    n_state = S_LOOK;
                end else begin
                    // position fixed: write it back and move on
                    work_we = 1'b1;
                    work_wa = r_i;
                    work_wd = r_cur;
                    if (r_i == r_lastpos) begin
                        n_state = S_FLUSH;
                    end else begin
                        n_i     = r_i + 1'b1;
                        n_state = S_POS;
                    end
                end
            end

            S_FLUSH: begin
                if (out_free) begin
                    push      = 1'b1;
                    push_last = 1'b1;
                    if (!r_pend_v) begin
                        // tours already equal: empty marker
                        push_first  = '0;
                        push_second = '0;
                        push_is     = 1'b0;
                    end
                    n_pend_v = 1'b0;
                    n_lc     = '0;
                    n_mask   = '0;
                    n_state  = S_LOAD;
                end
            end

            default: begin
                n_state = S_LOAD;
            end
        endcase
    end

    // Sequencer registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_LOAD;
            r_lc     <= '0;
            r_mask   <= '0;
            r_cnt    <= '0;
            r_pend_v <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_lc     <= n_lc;
            r_mask   <= n_mask;
            r_cnt    <= n_cnt;
            r_pend_v <= n_pend_v;
        end
        r_i       <= n_i;
        r_k       <= n_k;
        r_lastpos <= n_lastpos;
        r_cur     <= n_cur;
        r_tgt     <= n_tgt;
        r_pend_i  <= n_pend_i;
        r_pend_k  <= n_pend_k;
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (push) begin
            r_ovalid <= 1'b1;
        end else if (o_out.ready) begin
            r_ovalid <= 1'b0;
        end
        if (push) begin
            r_ofirst  <= push_first;
            r_osecond <= push_second;
            r_ois     <= push_is;
            r_olast   <= push_last;
        end
    end

    assign i_in.ready        = in_ready;
    assign o_out.valid       = r_ovalid;
    assign o_out.swap_first  = r_ofirst;
    assign o_out.swap_second = r_osecond;
    assign o_out.is_swap     = r_ois;
    assign o_out.last_swap   = r_olast;

endmodule

// File: rtl/pss_checker.sv
// ----------------------------------------------------------------------------
// pss_checker
// Port-level checks of the swap sequence block, bound to its top level.
// ----------------------------------------------------------------------------
module pss_checker import pss_pkg::*; (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_in_valid,
    input logic              i_in_ready,
    input logic              i_in_last,
    input logic              i_out_valid,
    input logic              i_out_ready,
    input logic [NODE_W-1:0] i_out_first,
    input logic [NODE_W-1:0] i_out_second,
    input logic              i_out_is_swap,
    input logic              i_out_last
);

    // A stalled result holds still
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_first) &&
        $stable(i_out_second) && $stable(i_out_is_swap) && $stable(i_out_last))
        else $error("result changed while stalled");

    // The closing element starts a run: no element taken right after it
    a_run_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready && i_in_last |=> !i_in_ready)
        else $error("element taken right after closing element");

    // Input only closes after a closing element
    a_ready_fall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(i_in_ready) |-> $past(i_in_valid && i_in_last))
        else $error("input closed without a closing element");

    // The empty marker is all zero and ends its run
    a_marker: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_is_swap |->
        i_out_last && (i_out_first == '0) && (i_out_second == '0))
        else $error("malformed empty marker");

endmodule

bind permutation_swap_sequence pss_checker u_pss_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_in.valid),
    .i_in_ready   (i_in.ready),
    .i_in_last    (i_in.last_element),
    .i_out_valid  (o_out.valid),
    .i_out_ready  (o_out.ready),
    .i_out_first  (o_out.swap_first),
    .i_out_second (o_out.swap_second),
    .i_out_is_swap(o_out.is_swap),
    .i_out_last   (o_out.last_swap)
);
